// File: rtl/ocg_pkg.sv
package ocg_pkg;

   // fixed field widths
   localparam int COORD_W = 9;
   localparam int VALUE_W = 8;
   localparam int TYPE_W = 3;
   localparam int CSR_W = 10;
   localparam int CSR_IDX_W = 3;
   localparam int PAD_W = 6;
   localparam int LIMIT_W = 7;
   localparam int SHIFT_CNT_W = 8;

   // internal coordinate arithmetic, wide enough for grids up to 4096 cells
   localparam int CRD_W = 14;

   localparam int DEF_MAX_WIDTH = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_LOAD = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_BUILD = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_MARK = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_POINT = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_LINE = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_LIMIT = 3'd4;

   typedef logic signed [CRD_W-1:0] crd_type;

   typedef struct packed {
      crd_type lo;
      crd_type hi;
   } span_type;

   typedef struct packed {
      logic load;
      logic step;
   } bres_ctl_type;

   typedef struct packed {
      crd_type x;
      crd_type y;
      logic    last;
   } bres_pos_type;

   // window of len cells from c-back, pushed into [0,n) and cut to it
   function automatic span_type span_of(crd_type c, crd_type back, crd_type len, crd_type n);
      span_type r;
      crd_type  s;
      crd_type  h;
      s = c - back;
      if (s < 0) s = '0;
      if (s + len > n) s = n - len;
      h = s + len - crd_type'(1);
      if (s < 0) s = '0;
      if (h > n - crd_type'(1)) h = n - crd_type'(1);
      r.lo = s;
      r.hi = h;
      return r;
   endfunction

endpackage

// File: rtl/occupancy_grid_line_collision.sv
// channel  | ports                                   | handshake
// item in  | req_type req_x_a req_y_a req_x_b ...    | start high while busy low
// item out | rsp_occupied rsp_status                 | rsp_valid, one cycle, no stall
// config   | csr_index csr_wdata                     | csr_wr_en, taken at once
// load: a row read, then the row written back; point query: one cell read; line query: one read per cell of the walk
// mark: a read, then a write, per box row (dynamic row read-modify-write on the row memory)
// clear: one dynamic row per cycle over all MAX_HEIGHT rows; the same pass runs after reset
// build: per map row, read and OR the window rows, shift 4*pad_x times, then read and write the row
// results go out as soon as ready; the receiver cannot stall them
module occupancy_grid_line_collision #(
   parameter int MAX_WIDTH = ocg_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ocg_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ocg_pkg::TYPE_W-1:0]      req_type,
   input  logic [ocg_pkg::COORD_W-1:0]     req_x_a,
   input  logic [ocg_pkg::COORD_W-1:0]     req_y_a,
   input  logic [ocg_pkg::COORD_W-1:0]     req_x_b,
   input  logic [ocg_pkg::COORD_W-1:0]     req_y_b,
   input  logic signed [ocg_pkg::VALUE_W-1:0] req_cell_value,
   output logic                            rsp_valid,
   output logic                            rsp_occupied,
   output logic                            rsp_status,
   input  logic                            csr_wr_en,
   input  logic [ocg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ocg_pkg::CSR_W-1:0]       csr_wdata
);
   import ocg_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CLR = 4'd1;
   localparam logic [3:0] ST_LD_WR = 4'd2;
   localparam logic [3:0] ST_MK_RD = 4'd3;
   localparam logic [3:0] ST_MK_WR = 4'd4;
   localparam logic [3:0] ST_WALK = 4'd5;
   localparam logic [3:0] ST_WEND = 4'd6;
   localparam logic [3:0] ST_BV_INIT = 4'd7;
   localparam logic [3:0] ST_BV = 4'd8;
   localparam logic [3:0] ST_BH = 4'd9;
   localparam logic [3:0] ST_BW = 4'd10;

   // configuration
   logic [CSR_W-1:0]   map_width_ff, map_height_ff;
   logic [PAD_W-1:0]   pad_x_ff, pad_y_ff;
   logic [LIMIT_W-1:0] free_limit_ff;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in, rsp_occ_ff, rsp_occ_in, rsp_sta_ff, rsp_sta_in;
   logic       clr_rsp_ff, clr_rsp_in, ld_bit_ff, ld_bit_in, hit_ff, hit_in, vld_d_ff, vld_d_in;
   crd_type    xa_ff, xa_in, ya_ff, ya_in, row_ff, row_in, row_end_ff, row_end_in;
   crd_type    xlo_ff, xlo_in, xhi_ff, xhi_in, yout_ff, yout_in, lx_ff, lx_in;
   logic [XW-1:0] x_d_ff, x_d_in;
   logic [SHIFT_CNT_W-1:0] k_ff, k_in;
   logic [MAX_WIDTH-1:0] col_ff, col_in, t_ff, t_in, f_ff, f_in;

   crd_type ew, eh, ax, ay, bx, by, padx_c, pady_c, lenx;
   logic    in_a, in_b, acc;
   span_type mk_sx, mk_sy, bv_sy;
   bres_ctl_type bctl;
   bres_pos_type bpos;
   logic [MAX_WIDTH-1:0] wmask, mmask, fsh, nbits, inf_row;

   // memory ports
   logic                   sta_we, sta_re, dyn_we, dyn_re;
   logic [YW-1:0]          sta_wa, sta_ra, dyn_wa, dyn_ra;
   logic [2*MAX_WIDTH-1:0] sta_wd, sta_q;
   logic [MAX_WIDTH-1:0]   dyn_wd, dyn_q;

   // static rows: inflated bits in the upper half, raw bits in the lower
   ocg_ram #(.WIDTH(2*MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_sta_ram (
      .clock(clock), .wr_en(sta_we), .wr_addr(sta_wa), .wr_data(sta_wd),
      .rd_en(sta_re), .rd_addr(sta_ra), .rd_data(sta_q)
   );

   ocg_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_dyn_ram (
      .clock(clock), .wr_en(dyn_we), .wr_addr(dyn_wa), .wr_data(dyn_wd),
      .rd_en(dyn_re), .rd_addr(dyn_ra), .rd_data(dyn_q)
   );

   ocg_bres u_bres (
      .clock(clock), .ctl(bctl), .xa(ax), .ya(ay), .xb(bx), .yb(by), .pos(bpos)
   );

   // map size in use and request decode
   always_comb begin
      ew = (crd_type'(map_width_ff) < crd_type'(MAX_WIDTH)) ?
           crd_type'(map_width_ff) : crd_type'(MAX_WIDTH);
      eh = (crd_type'(map_height_ff) < crd_type'(MAX_HEIGHT)) ?
           crd_type'(map_height_ff) : crd_type'(MAX_HEIGHT);
      padx_c = crd_type'(pad_x_ff);
      pady_c = crd_type'(pad_y_ff);
      lenx = padx_c + padx_c + padx_c + padx_c + crd_type'(1);
      ax = crd_type'(req_x_a);
      ay = crd_type'(req_y_a);
      bx = (req_type == REQ_LINE) ? crd_type'(req_x_b) : ax;
      by = (req_type == REQ_LINE) ? crd_type'(req_y_b) : ay;
      in_a = (ax < ew) && (ay < eh);
      in_b = (bx < ew) && (by < eh);
      acc = start && !busy;
      mk_sx = span_of(ax, padx_c + crd_type'(1), padx_c + padx_c + crd_type'(2), ew);
      mk_sy = span_of(ay, pady_c + crd_type'(1), pady_c + pady_c + crd_type'(2), eh);
      bv_sy = span_of(yout_ff, pady_c, pady_c + pady_c + pady_c + pady_c + crd_type'(1), eh);
   end

   // per-column masks and the horizontal inflation pick
   always_comb begin
      fsh = f_ff << pad_x_ff;
      inf_row = sta_q[2*MAX_WIDTH-1:MAX_WIDTH];
      for (int i = 0; i < MAX_WIDTH; i++) begin
         wmask[i] = (CRD_W'(i) < ew);
         mmask[i] = (CRD_W'(i) >= xlo_ff) && (CRD_W'(i) <= xhi_ff);
         if (CRD_W'(i) < padx_c) nbits[i] = f_ff[0];
         else if (CRD_W'(i) - padx_c > lx_ff) nbits[i] = f_ff[XW'(lx_ff)];
         else nbits[i] = fsh[i];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = 1'b0;
      rsp_occ_in = rsp_occ_ff;
      rsp_sta_in = rsp_sta_ff;
      clr_rsp_in = clr_rsp_ff;
      ld_bit_in = ld_bit_ff;
      hit_in = hit_ff;
      vld_d_in = vld_d_ff;
      xa_in = xa_ff;
      ya_in = ya_ff;
      row_in = row_ff;
      row_end_in = row_end_ff;
      xlo_in = xlo_ff;
      xhi_in = xhi_ff;
      yout_in = yout_ff;
      lx_in = lx_ff;
      x_d_in = x_d_ff;
      k_in = k_ff;
      col_in = col_ff;
      t_in = t_ff;
      f_in = f_ff;
      bctl = '0;
      sta_we = 1'b0;
      sta_re = 1'b0;
      sta_wa = YW'(row_ff);
      sta_ra = YW'(row_ff);
      sta_wd = sta_q;
      dyn_we = 1'b0;
      dyn_re = 1'b0;
      dyn_wa = YW'(row_ff);
      dyn_ra = YW'(row_ff);
      dyn_wd = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               xa_in = ax;
               ya_in = ay;
               unique case (req_type)
                  REQ_LOAD: begin
                     if (!in_a) begin
                        rsp_valid_in = 1'b1; rsp_occ_in = 1'b1; rsp_sta_in = 1'b1;
                     end else begin
                        ld_bit_in = req_cell_value[VALUE_W-1] ||
                                    (req_cell_value[VALUE_W-2:0] > free_limit_ff);
                        sta_re = 1'b1;
                        sta_ra = YW'(ay);
                        state_in = ST_LD_WR;
                     end
                  end
                  REQ_BUILD: begin
                     if (ew == 0 || eh == 0) begin
                        rsp_valid_in = 1'b1; rsp_occ_in = 1'b0; rsp_sta_in = 1'b0;
                     end else begin
                        yout_in = '0;
                        state_in = ST_BV_INIT;
                     end
                  end
                  REQ_CLEAR: begin
                     row_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in = ST_CLR;
                  end
                  REQ_MARK: begin
                     if (!in_a) begin
                        rsp_valid_in = 1'b1; rsp_occ_in = 1'b1; rsp_sta_in = 1'b1;
                     end else begin
                        xlo_in = mk_sx.lo;
                        xhi_in = mk_sx.hi;
                        row_in = mk_sy.lo;
                        row_end_in = mk_sy.hi;
                        state_in = ST_MK_RD;
                     end
                  end
                  REQ_POINT, REQ_LINE: begin
                     if (!in_a || !in_b) begin
                        rsp_valid_in = 1'b1; rsp_occ_in = 1'b1; rsp_sta_in = 1'b1;
                     end else begin
                        bctl.load = 1'b1;
                        hit_in = 1'b0;
                        vld_d_in = 1'b0;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1; rsp_occ_in = 1'b0; rsp_sta_in = 1'b0;
                  end
               endcase
            end
         end

         // dynamic grid clearing sweep
         ST_CLR: begin
            dyn_we = 1'b1;
            dyn_wd = '0;
            row_in = row_ff + crd_type'(1);
            if (row_ff == crd_type'(MAX_HEIGHT - 1)) begin
               state_in = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1; rsp_occ_in = 1'b0; rsp_sta_in = 1'b0;
               end
            end
         end

         // raw cell write back
         ST_LD_WR: begin
            sta_we = 1'b1;
            sta_wa = YW'(ya_ff);
            sta_wd = sta_q;
            sta_wd[XW'(xa_ff)] = ld_bit_ff;
            rsp_valid_in = 1'b1; rsp_occ_in = 1'b0; rsp_sta_in = 1'b0;
            state_in = ST_IDLE;
         end

         // mark box, one row read-modify-write at a time
         ST_MK_RD: begin
            dyn_re = 1'b1;
            state_in = ST_MK_WR;
         end

         ST_MK_WR: begin
            dyn_we = 1'b1;
            dyn_wd = dyn_q | mmask;
            if (row_ff == row_end_ff) begin
               rsp_valid_in = 1'b1; rsp_occ_in = 1'b0; rsp_sta_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + crd_type'(1);
               state_in = ST_MK_RD;
            end
         end

         // line walk, one cell read per cycle
         ST_WALK: begin
            sta_re = 1'b1;
            dyn_re = 1'b1;
            sta_ra = YW'(bpos.y);
            dyn_ra = YW'(bpos.y);
            x_d_in = XW'(bpos.x);
            vld_d_in = 1'b1;
            if (vld_d_ff) hit_in = hit_ff | inf_row[x_d_ff] | dyn_q[x_d_ff];
            if (bpos.last) state_in = ST_WEND;
            else bctl.step = 1'b1;
         end

         ST_WEND: begin
            vld_d_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_occ_in = hit_ff | inf_row[x_d_ff] | dyn_q[x_d_ff];
            rsp_sta_in = 1'b0;
            state_in = ST_IDLE;
         end

         // build: set up the row window for one output row
         ST_BV_INIT: begin
            row_in = bv_sy.lo;
            row_end_in = bv_sy.hi;
            col_in = '0;
            vld_d_in = 1'b0;
            k_in = {pad_x_ff, 2'b00};
            lx_in = (ew > lenx) ? ew - lenx : '0;
            state_in = ST_BV;
         end

         // build: OR the raw rows of the window
         ST_BV: begin
            if (row_ff <= row_end_ff) begin
               sta_re = 1'b1;
               row_in = row_ff + crd_type'(1);
            end
            vld_d_in = (row_ff <= row_end_ff);
            if (vld_d_ff) col_in = col_ff | (sta_q[MAX_WIDTH-1:0] & wmask);
            if (row_ff > row_end_ff && !vld_d_ff) begin
               t_in = col_ff;
               f_in = col_ff;
               state_in = ST_BH;
            end
         end

         // build: forward OR along x, one column shift per cycle
         ST_BH: begin
            if (k_ff != 0) begin
               t_in = t_ff >> 1;
               f_in = f_ff | (t_ff >> 1);
               k_in = k_ff - SHIFT_CNT_W'(1);
            end else begin
               sta_re = 1'b1;
               sta_ra = YW'(yout_ff);
               state_in = ST_BW;
            end
         end

         // build: write the inflated row, keeping bits outside the map
         ST_BW: begin
            sta_we = 1'b1;
            sta_wa = YW'(yout_ff);
            sta_wd = {(inf_row & ~wmask) | (nbits & wmask), sta_q[MAX_WIDTH-1:0]};
            if (yout_ff == eh - crd_type'(1)) begin
               rsp_valid_in = 1'b1; rsp_occ_in = 1'b0; rsp_sta_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               yout_in = yout_ff + crd_type'(1);
               state_in = ST_BV_INIT;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         row_ff <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         map_width_ff <= CSR_W'(512);
         map_height_ff <= CSR_W'(512);
         pad_x_ff <= PAD_W'(5);
         pad_y_ff <= PAD_W'(5);
         free_limit_ff <= LIMIT_W'(80);
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_d_ff <= vld_d_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MAP_WIDTH:  map_width_ff <= csr_wdata;
               CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
               CSR_PAD_X:      pad_x_ff <= csr_wdata[PAD_W-1:0];
               CSR_PAD_Y:      pad_y_ff <= csr_wdata[PAD_W-1:0];
               CSR_FREE_LIMIT: free_limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_occ_ff <= rsp_occ_in;
      rsp_sta_ff <= rsp_sta_in;
      ld_bit_ff <= ld_bit_in;
      hit_ff <= hit_in;
      xa_ff <= xa_in;
      ya_ff <= ya_in;
      row_end_ff <= row_end_in;
      xlo_ff <= xlo_in;
      xhi_ff <= xhi_in;
      yout_ff <= yout_in;
      lx_ff <= lx_in;
      x_d_ff <= x_d_in;
      k_ff <= k_in;
      col_ff <= col_in;
      t_ff <= t_in;
      f_ff <= f_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_occupied = rsp_occ_ff;
   assign rsp_status = rsp_sta_ff;

endmodule

// File: rtl/ocg_ram.sv
module ocg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ocg_bres.sv
module ocg_bres (
   input  logic                  clock,
   input  ocg_pkg::bres_ctl_type ctl,
   input  ocg_pkg::crd_type      xa,
   input  ocg_pkg::crd_type      ya,
   input  ocg_pkg::crd_type      xb,
   input  ocg_pkg::crd_type      yb,
   output ocg_pkg::bres_pos_type pos
);
   import ocg_pkg::*;

   crd_type x_ff, x_in, y_ff, y_in, err_ff, err_in, cnt_ff, cnt_in;
   crd_type inc_a_ff, inc_a_in, inc_b_ff, inc_b_in;
   logic    steep_ff, steep_in, xneg_ff, xneg_in, yneg_ff, yneg_in;
   crd_type dx, dy, adx, ady, major, minor;
   logic    side;

   // line set-up on load, one cell per step afterwards
   always_comb begin
      dx = xb - xa;
      dy = yb - ya;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      major = (ady > adx) ? ady : adx;
      minor = (ady > adx) ? adx : ady;
      side = (err_ff >= 0);
      x_in = x_ff;
      y_in = y_ff;
      err_in = err_ff;
      cnt_in = cnt_ff;
      inc_a_in = inc_a_ff;
      inc_b_in = inc_b_ff;
      steep_in = steep_ff;
      xneg_in = xneg_ff;
      yneg_in = yneg_ff;
      if (ctl.load) begin
         x_in = xa;
         y_in = ya;
         steep_in = (ady > adx);
         xneg_in = (dx < 0);
         yneg_in = (dy < 0);
         inc_a_in = minor + minor;
         inc_b_in = minor + minor - major - major;
         err_in = minor + minor - major;
         cnt_in = major;
      end else if (ctl.step && cnt_ff != 0) begin
         err_in = err_ff + (side ? inc_b_ff : inc_a_ff);
         cnt_in = cnt_ff - crd_type'(1);
         if (!steep_ff || side) x_in = xneg_ff ? x_ff - crd_type'(1) : x_ff + crd_type'(1);
         if (steep_ff || side) y_in = yneg_ff ? y_ff - crd_type'(1) : y_ff + crd_type'(1);
         if (steep_ff && !side) x_in = x_ff;
         if (!steep_ff && !side) y_in = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      err_ff <= err_in;
      cnt_ff <= cnt_in;
      inc_a_ff <= inc_a_in;
      inc_b_ff <= inc_b_in;
      steep_ff <= steep_in;
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
   end

   assign pos.x = x_ff;
   assign pos.y = y_ff;
   assign pos.last = (cnt_ff == 0);

endmodule

// File: rtl/ocg_checker.sv
module ocg_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_occupied,
   input logic rsp_status
);

   // an accepted item keeps the block busy or answers at once
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither busy nor answered");

   // no result while an item is still at work
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // no result out of nothing
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_valid)
      else $error("result without an item");

   // an index outside the map always answers occupied
   a_bad_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> rsp_occupied)
      else $error("outside index not occupied");

endmodule

bind occupancy_grid_line_collision ocg_checker u_ocg_checker (.*);

// File: tb/tb_occupancy_grid_line_collision.sv
module tb_occupancy_grid_line_collision;
   timeunit 1ns;
   timeprecision 1ps;
   import ocg_pkg::*;

   localparam int GW = DEF_MAX_WIDTH;
   localparam int GH = DEF_MAX_HEIGHT;
   localparam int PS = GW + 1;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      logic [TYPE_W-1:0]         kind;
      logic [COORD_W-1:0]        xa;
      logic [COORD_W-1:0]        ya;
      logic [COORD_W-1:0]        xb;
      logic [COORD_W-1:0]        yb;
      logic signed [VALUE_W-1:0] val;
   } grid_req_type;

   typedef struct {
      grid_req_type req;
      bit           fixed;
      logic         occ;
      logic         bad;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [TYPE_W-1:0] req_type = '0;
   logic [COORD_W-1:0] req_x_a = '0;
   logic [COORD_W-1:0] req_y_a = '0;
   logic [COORD_W-1:0] req_x_b = '0;
   logic [COORD_W-1:0] req_y_b = '0;
   logic signed [VALUE_W-1:0] req_cell_value = '0;
   logic rsp_valid;
   logic rsp_occupied;
   logic rsp_status;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   occupancy_grid_line_collision dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow grids and registers
   bit raw_g [GW*GH];
   bit infl_g [GW*GH];
   bit dyn_g [GW*GH];
   int unsigned prefix [PS*(GH+1)];
   logic [9:0] sh_w = 10'd512, sh_h = 10'd512;
   logic [5:0] sh_px = 6'd5, sh_py = 6'd5;
   logic [6:0] sh_limit = 7'd80;

   logic [1:0] pending_answers [$];
   int errors = 0;
   int items_sent = 0;
   int answers_seen = 0;
   int idle_cycles = 0;
   bit allow_gaps = 1'b1;
   int query_w = 0, query_h = 0;

   function automatic int eff_w();
      return (sh_w < GW) ? int'(sh_w) : GW;
   endfunction

   function automatic int eff_h();
      return (sh_h < GH) ? int'(sh_h) : GH;
   endfunction

   function automatic bit on_map(int x, int y);
      return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
   endfunction

   // window of len cells from c-back, pushed into the axis and cut to it
   function automatic void clamp_span(input int c, input int back, input int len,
                                      input int n, output int lo, output int hi);
      int s;
      s = c - back;
      if (s < 0) s = 0;
      if (s + len > n) s = n - len;
      hi = s + len - 1;
      if (s < 0) s = 0;
      if (hi > n - 1) hi = n - 1;
      lo = s;
   endfunction

   function automatic void inflate_grid();
      int w, h, x0, x1, y0, y1, px, py;
      int unsigned v;
      w = eff_w();
      h = eff_h();
      px = int'(sh_px);
      py = int'(sh_py);
      for (int y = 0; y <= h; y++)
         for (int x = 0; x <= w; x++) begin
            v = 0;
            if (x > 0 && y > 0)
               v = raw_g[(y-1)*GW + x-1] + prefix[(y-1)*PS + x] + prefix[y*PS + x-1]
                   - prefix[(y-1)*PS + x-1];
            prefix[y*PS + x] = v;
         end
      for (int y = 0; y < h; y++) begin
         clamp_span(y, py, 4*py + 1, h, y0, y1);
         for (int x = 0; x < w; x++) begin
            clamp_span(x, px, 4*px + 1, w, x0, x1);
            infl_g[y*GW + x] = (prefix[(y1+1)*PS + x1+1] - prefix[y0*PS + x1+1]
                                - prefix[(y1+1)*PS + x0] + prefix[y0*PS + x0]) != 0;
         end
      end
   endfunction

   function automatic bit cell_hit(int x, int y);
      return infl_g[y*GW + x] || dyn_g[y*GW + x];
   endfunction

   // bresenham walk, both endpoints included
   function automatic bit line_blocked(int xa, int ya, int xb, int yb);
      int dx, dy, sx, sy, adx, ady, major, minor, err, x, y;
      bit steep, side;
      dx = xb - xa;
      dy = yb - ya;
      sx = dx < 0 ? -1 : 1;
      sy = dy < 0 ? -1 : 1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      steep = ady > adx;
      major = steep ? ady : adx;
      minor = steep ? adx : ady;
      err = 2*minor - major;
      x = xa;
      y = ya;
      if (cell_hit(x, y)) return 1'b1;
      for (int k = 0; k < major; k++) begin
         side = err >= 0;
         err += side ? 2*minor - 2*major : 2*minor;
         if (steep) begin
            y += sy;
            if (side) x += sx;
         end else begin
            x += sx;
            if (side) y += sy;
         end
         if (cell_hit(x, y)) return 1'b1;
      end
      return 1'b0;
   endfunction

   // expected {occupied, status}; updates the shadow grids
   function automatic logic [1:0] grid_answer(grid_req_type r);
      int xa, ya, xb, yb, x0, x1, y0, y1, px, py;
      xa = int'(r.xa);
      ya = int'(r.ya);
      xb = int'(r.xb);
      yb = int'(r.yb);
      px = int'(sh_px);
      py = int'(sh_py);
      case (r.kind)
         REQ_LOAD: begin
            if (!on_map(xa, ya)) return 2'b11;
            raw_g[ya*GW + xa] = !(r.val >= 0 && int'(r.val) <= int'(sh_limit));
         end
         REQ_BUILD: inflate_grid();
         REQ_CLEAR: dyn_g = '{default: 1'b0};
         REQ_MARK: begin
            if (!on_map(xa, ya)) return 2'b11;
            clamp_span(xa, px + 1, 2*px + 2, eff_w(), x0, x1);
            clamp_span(ya, py + 1, 2*py + 2, eff_h(), y0, y1);
            for (int y = y0; y <= y1; y++)
               for (int x = x0; x <= x1; x++)
                  dyn_g[y*GW + x] = 1'b1;
            dyn_g[ya*GW + xa] = 1'b1;
         end
         REQ_POINT: begin
            if (!on_map(xa, ya)) return 2'b11;
            return {cell_hit(xa, ya), 1'b0};
         end
         REQ_LINE: begin
            if (!on_map(xa, ya) || !on_map(xb, yb)) return 2'b11;
            return {line_blocked(xa, ya, xb, yb), 1'b0};
         end
         default: ;
      endcase
      return 2'b00;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
   endtask

   // answer checker
   always @(posedge clock) begin
      logic [1:0] exp_ans;
      if (!reset && rsp_valid === 1'b1) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            report_mismatch("answer with no item outstanding");
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_occupied !== exp_ans[1])
               report_mismatch($sformatf("occupied %b, expected %b", rsp_occupied, exp_ans[1]));
            if (rsp_status !== exp_ans[0])
               report_mismatch($sformatf("status %b, expected %b", rsp_status, exp_ans[0]));
         end
      end
   end

   // watchdog on cycles with nothing moving
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog expired, %0d answers outstanding",
                  $realtime, pending_answers.size());
         $display("occupancy_grid_line_collision test failed");
         $finish;
      end
   end

   task automatic send_item(input grid_req_type r, input bit fixed = 1'b0,
                            input logic [1:0] fixed_ans = 2'b00);
      logic [1:0] ans;
      start <= 1'b1;
      req_type <= r.kind;
      req_x_a <= r.xa;
      req_y_a <= r.ya;
      req_x_b <= r.xb;
      req_y_b <= r.yb;
      req_cell_value <= r.val;
      do @(posedge clock); while (busy !== 1'b0);
      ans = grid_answer(r);
      pending_answers = {pending_answers, (fixed ? fixed_ans : ans)};
      items_sent++;
      // random sender gap
      if (allow_gaps && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MAP_WIDTH: sh_w = data;
         CSR_MAP_HEIGHT: sh_h = data;
         CSR_PAD_X: sh_px = data[PAD_W-1:0];
         CSR_PAD_Y: sh_py = data[PAD_W-1:0];
         CSR_FREE_LIMIT: sh_limit = data[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_map(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h,
                          input logic [CSR_W-1:0] px, input logic [CSR_W-1:0] py,
                          input logic [CSR_W-1:0] lim);
      drain();
      write_csr(CSR_MAP_WIDTH, w);
      write_csr(CSR_MAP_HEIGHT, h);
      write_csr(CSR_PAD_X, px);
      write_csr(CSR_PAD_Y, py);
      write_csr(CSR_FREE_LIMIT, lim);
      csr_wr_en <= 1'b0;
   endtask

   function automatic grid_req_type noise_req();
      grid_req_type r;
      r.kind = REQ_POINT;
      r.xa = COORD_W'($urandom);
      r.ya = COORD_W'($urandom);
      r.xb = COORD_W'($urandom);
      r.yb = COORD_W'($urandom);
      r.val = VALUE_W'($urandom);
      return r;
   endfunction

   // load every cell of the map, then inflate
   task automatic load_and_build();
      grid_req_type r;
      for (int y = 0; y < eff_h(); y++)
         for (int x = 0; x < eff_w(); x++) begin
            r = noise_req();
            r.kind = REQ_LOAD;
            r.xa = COORD_W'(x);
            r.ya = COORD_W'(y);
            if ($urandom_range(0, 1)) r.val = VALUE_W'($urandom_range(0, 100));
            send_item(r);
         end
      r = noise_req();
      r.kind = REQ_BUILD;
      send_item(r);
      query_w = eff_w();
      query_h = eff_h();
   endtask

   task automatic random_items(input int n, input bit can_build);
      grid_req_type r;
      int pick;
      for (int i = 0; i < n; i++) begin
         r = noise_req();
         pick = $urandom_range(0, 99);
         r.xa = COORD_W'($urandom_range(0, eff_w() - 1));
         r.ya = COORD_W'($urandom_range(0, eff_h() - 1));
         if (pick < 20) begin
            r.kind = REQ_LOAD;
         end else if (pick < 32) begin
            r.kind = REQ_MARK;
         end else if (pick < 36) begin
            r.kind = REQ_CLEAR;
         end else if (pick < 39) begin
            r.kind = can_build ? REQ_BUILD : REQ_CLEAR;
         end else if (pick < 42) begin
            r.kind = TYPE_W'($urandom_range(6, 7));
         end else if (pick < 50 && (eff_w() < GW || eff_h() < GH)) begin
            // index off the map, any request that takes one
            r.kind = $urandom_range(0, 1) ? REQ_LINE : $urandom_range(0, 1) ? REQ_LOAD :
                     $urandom_range(0, 1) ? REQ_MARK : REQ_POINT;
            if (eff_w() < GW && (eff_h() == GH || $urandom_range(0, 1)))
               r.xa = COORD_W'($urandom_range(eff_w(), GW - 1));
            else
               r.ya = COORD_W'($urandom_range(eff_h(), GH - 1));
            if (r.kind == REQ_LINE && $urandom_range(0, 1)) begin
               r.xb = r.xa;
               r.yb = r.ya;
               r.xa = COORD_W'($urandom_range(0, query_w - 1));
               r.ya = COORD_W'($urandom_range(0, query_h - 1));
            end
         end else begin
            r.kind = (pick < 72) ? REQ_POINT : REQ_LINE;
            r.xa = COORD_W'($urandom_range(0, query_w - 1));
            r.ya = COORD_W'($urandom_range(0, query_h - 1));
            r.xb = COORD_W'($urandom_range(0, query_w - 1));
            r.yb = COORD_W'($urandom_range(0, query_h - 1));
         end
         send_item(r);
      end
   endtask

   directed_row_type dir_rows [$];

   function automatic directed_row_type drow(logic [TYPE_W-1:0] k, int xa, int ya, int xb,
                                             int yb, int v, bit fixed, logic [1:0] ans);
      directed_row_type d;
      d.req.kind = k;
      d.req.xa = COORD_W'(xa);
      d.req.ya = COORD_W'(ya);
      d.req.xb = COORD_W'(xb);
      d.req.yb = COORD_W'(yb);
      d.req.val = VALUE_W'(v);
      d.fixed = fixed;
      {d.occ, d.bad} = ans;
      return d;
   endfunction

   function automatic void stash_row(directed_row_type d);
      dir_rows = {dir_rows, d};
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part on a 4 x 3 map, narrow x padding, free limit 100
      set_map(10'd4, 10'd3, 10'd0, 10'd1, 10'd100);
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 3; x++)
            stash_row(drow(REQ_LOAD, x, y, 511, 511, (x + y == 0) ? 100 :
                           (x == 1) ? 0 : 55, 1'b1, 2'b00));
      stash_row(drow(REQ_LOAD, 3, 0, 0, 0, -128, 1'b1, 2'b00));
      stash_row(drow(REQ_LOAD, 3, 1, 0, 0, -1, 1'b1, 2'b00));
      stash_row(drow(REQ_LOAD, 3, 2, 0, 0, 101, 1'b1, 2'b00));
      stash_row(drow(REQ_BUILD, 0, 0, 0, 0, 127, 1'b1, 2'b00));
      stash_row(drow(REQ_POINT, 1, 2, 0, 0, 0, 1'b0, 2'b00));
      stash_row(drow(REQ_LINE, 0, 0, 2, 2, 0, 1'b0, 2'b00));
      stash_row(drow(REQ_LINE, 0, 1, 3, 2, 0, 1'b0, 2'b00));
      stash_row(drow(REQ_MARK, 0, 0, 0, 0, 0, 1'b1, 2'b00));
      stash_row(drow(REQ_POINT, 1, 2, 0, 0, 0, 1'b0, 2'b00));
      stash_row(drow(REQ_CLEAR, 0, 0, 0, 0, 0, 1'b1, 2'b00));
      stash_row(drow(REQ_POINT, 1, 2, 0, 0, 0, 1'b0, 2'b00));
      stash_row(drow(3'd6, 5, 5, 5, 5, 0, 1'b1, 2'b00));
      stash_row(drow(3'd7, 511, 511, 511, 511, 127, 1'b1, 2'b00));
      // indexes off the map
      stash_row(drow(REQ_LOAD, 511, 0, 0, 0, 0, 1'b1, 2'b11));
      stash_row(drow(REQ_MARK, 0, 511, 0, 0, 0, 1'b1, 2'b11));
      stash_row(drow(REQ_POINT, 4, 0, 0, 0, 0, 1'b1, 2'b11));
      stash_row(drow(REQ_LINE, 0, 0, 0, 3, 0, 1'b1, 2'b11));
      foreach (dir_rows[i])
         send_item(dir_rows[i].req, dir_rows[i].fixed, {dir_rows[i].occ, dir_rows[i].bad});

      // mid-size map, mixed traffic with rebuilds
      set_map(10'd12, 10'd10, 10'd2, 10'd1, 10'd50);
      load_and_build();
      random_items(100, 1'b1);

      // oversize map registers and widest padding; queries stay on built cells
      set_map(10'h3FF, 10'd1023, 10'h3FF, 10'd63, 10'd0);
      random_items(80, 1'b0);

      // single-cell map
      set_map(10'd1, 10'd1, 10'd0, 10'd0, 10'd0);
      load_and_build();
      random_items(40, 1'b1);

      // small map under reset-like padding, windows wider than the map
      set_map(10'd9, 10'd7, 10'd5, 10'd5, 10'd80);
      load_and_build();
      random_items(75, 1'b1);
      allow_gaps = 1'b0;
      random_items(75, 1'b1);

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d items, %0d answers: loads, inflation builds, marks, clears,",
               items_sent, answers_seen);
      $display("point and line queries, off-map indexes and unknown requests over five maps");
      if (errors == 0 && pending_answers.size() == 0)
         $display("occupancy_grid_line_collision test passed");
      else
         $display("occupancy_grid_line_collision test failed");
      $finish;
   end
endmodule
